// ===== design/pnn_pkg.sv =====
// shared types and constants for the newell polygon normal block
// no dependencies
`default_nettype none
package pnn_pkg;
  localparam int CoordWidth = 16;
  localparam int AccWidth   = 44;
  localparam int OutWidth   = 16;
  localparam int FracBits   = 14;
  localparam int ScaleBits  = 30;
  localparam int SqWidth    = 63;
  localparam int LenWidth   = 32;
  localparam int NumWidth   = AccWidth + 1;

  typedef struct packed {
    logic [AccWidth-1:0] sx;
    logic [AccWidth-1:0] sy;
    logic [AccWidth-1:0] sz;
  } sums_t;
endpackage
`default_nettype wire

// ===== design/pnn_front.sv =====
// front end: takes vertices, accumulates newell cross terms, closes the ring
// depends on pnn_pkg
`default_nettype none
module pnn_front (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  push_i,
  output logic                                 full_o,
  input  wire signed [pnn_pkg::CoordWidth-1:0] vertex_x_i,
  input  wire signed [pnn_pkg::CoordWidth-1:0] vertex_y_i,
  input  wire signed [pnn_pkg::CoordWidth-1:0] vertex_z_i,
  input  wire                                  last_vertex_i,
  output logic                                 q_push_o,
  input  wire                                  q_full_i,
  output pnn_pkg::sums_t                       q_data_o
);
  localparam int W = pnn_pkg::CoordWidth;
  localparam int A = pnn_pkg::AccWidth;

  logic signed [W-1:0] fx_q, fy_q, fz_q, px_q, py_q, pz_q;
  logic [A-1:0] sx_q, sy_q, sz_q;
  logic ring_open_q, closing_q;
  logic signed [W-1:0] cx, cy, cz;
  logic signed [W:0] dx, dy, dz, ax, ay, az;
  logic signed [2*W+1:0] tx, ty, tz;
  logic [A-1:0] nx, ny, nz;
  logic accept;

  assign accept = push_i && !closing_q;
  assign full_o = closing_q;

  // current edge end: first vertex while closing the ring
  assign cx = closing_q ? fx_q : vertex_x_i;
  assign cy = closing_q ? fy_q : vertex_y_i;
  assign cz = closing_q ? fz_q : vertex_z_i;

  assign dx = {px_q[W-1], px_q} - {cx[W-1], cx};
  assign dy = {py_q[W-1], py_q} - {cy[W-1], cy};
  assign dz = {pz_q[W-1], pz_q} - {cz[W-1], cz};
  assign ax = {px_q[W-1], px_q} + {cx[W-1], cx};
  assign ay = {py_q[W-1], py_q} + {cy[W-1], cy};
  assign az = {pz_q[W-1], pz_q} + {cz[W-1], cz};
  assign tx = dy * az;
  assign ty = dz * ax;
  assign tz = dx * ay;

  assign nx = sx_q + {{(A-2*W-2){tx[2*W+1]}}, tx};
  assign ny = sy_q + {{(A-2*W-2){ty[2*W+1]}}, ty};
  assign nz = sz_q + {{(A-2*W-2){tz[2*W+1]}}, tz};

  assign q_push_o = closing_q && !q_full_i;
  assign q_data_o = '{sx: nx, sy: ny, sz: nz};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_open_q <= 1'b0;
      closing_q   <= 1'b0;
      fx_q <= '0; fy_q <= '0; fz_q <= '0;
      px_q <= '0; py_q <= '0; pz_q <= '0;
      sx_q <= '0; sy_q <= '0; sz_q <= '0;
    end else if (closing_q) begin
      if (!q_full_i) begin
        closing_q   <= 1'b0;
        ring_open_q <= 1'b0;
        sx_q <= nx; sy_q <= ny; sz_q <= nz;
      end
    end else if (accept) begin
      closing_q <= last_vertex_i;
      px_q <= vertex_x_i; py_q <= vertex_y_i; pz_q <= vertex_z_i;
      if (!ring_open_q) begin
        ring_open_q <= 1'b1;
        fx_q <= vertex_x_i; fy_q <= vertex_y_i; fz_q <= vertex_z_i;
        sx_q <= '0; sy_q <= '0; sz_q <= '0;
      end else begin
        sx_q <= nx; sy_q <= ny; sz_q <= nz;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/pnn_queue.sv =====
// two-entry queue of finished sums between front and back
// depends on pnn_pkg
`default_nettype none
module pnn_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  pnn_pkg::sums_t data_i,
  output logic           full_o,
  input  wire            pop_i,
  output logic           empty_o,
  output pnn_pkg::sums_t data_o
);
  pnn_pkg::sums_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

// ===== design/pnn_back.sv =====
// back end: scales the sums, square root and three divisions, output register
// depends on pnn_pkg
`default_nettype none
module pnn_back (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                q_empty_i,
  input  pnn_pkg::sums_t                     q_data_i,
  output logic                               q_pop_o,
  input  wire                                pop_i,
  output logic                               empty_o,
  output logic signed [pnn_pkg::OutWidth-1:0] normal_x_o,
  output logic signed [pnn_pkg::OutWidth-1:0] normal_y_o,
  output logic signed [pnn_pkg::OutWidth-1:0] normal_z_o,
  output logic                               degenerate_o
);
  localparam int A  = pnn_pkg::AccWidth;
  localparam int O  = pnn_pkg::OutWidth;
  localparam int SQ = pnn_pkg::SqWidth;
  localparam int L  = pnn_pkg::LenWidth;
  localparam int N  = pnn_pkg::NumWidth;
  localparam int S  = pnn_pkg::ScaleBits;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_SQ    = 3'd2;
  localparam logic [2:0] S_SQRT  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_q;
  logic [A-1:0] mag_q [3];
  logic [2:0] neg_q;
  logic [1:0] idx_q;
  logic [2*S-1:0] prod_q;
  logic [SQ-1:0] v_q, res_q, bit_q;
  logic [N-1:0] num_q;
  logic [L-1:0] rem_q;
  logic [5:0] cnt_q;
  logic [O-1:0] nrm_q [3];
  logic deg_q;
  logic out_valid_q;
  logic [O-1:0] ox_q, oy_q, oz_q;
  logic od_q;

  logic [A-1:0] in_mag [3];
  logic [A-1:0] mag_sel;
  logic [SQ-1:0] trial;
  logic [L:0] rem2;
  logic ge;
  logic [L-1:0] len;
  logic [O-1:0] q16;
  logic out_free;

  assign in_mag[0] = q_data_i.sx[A-1] ? -q_data_i.sx : q_data_i.sx;
  assign in_mag[1] = q_data_i.sy[A-1] ? -q_data_i.sy : q_data_i.sy;
  assign in_mag[2] = q_data_i.sz[A-1] ? -q_data_i.sz : q_data_i.sz;

  always_comb begin
    unique case (idx_q)
      2'd0:    mag_sel = mag_q[0];
      2'd1:    mag_sel = mag_q[1];
      2'd2:    mag_sel = mag_q[2];
      default: mag_sel = '0;
    endcase
  end

  assign trial = res_q + bit_q;
  assign len   = res_q[L-1:0];
  assign rem2  = {rem_q, num_q[N-1]};
  assign ge    = rem2 >= {1'b0, len};
  assign q16   = num_q[O-1:0];
  assign out_free = !out_valid_q || pop_i;
  assign q_pop_o  = (state_q == S_IDLE) && !q_empty_i;

  assign empty_o      = !out_valid_q;
  assign normal_x_o   = ox_q;
  assign normal_y_o   = oy_q;
  assign normal_z_o   = oz_q;
  assign degenerate_o = od_q;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        mag_q[0] <= in_mag[0];
        mag_q[1] <= in_mag[1];
        mag_q[2] <= in_mag[2];
        neg_q <= {q_data_i.sz[A-1], q_data_i.sy[A-1], q_data_i.sx[A-1]};
        nrm_q[0] <= '0; nrm_q[1] <= '0; nrm_q[2] <= '0;
        deg_q <= ~|{in_mag[0], in_mag[1], in_mag[2]};
        v_q   <= '0;
      end
      S_SHIFT: begin
        // scale until every magnitude is below 2^30
        if (|{mag_q[0][A-1:S], mag_q[1][A-1:S], mag_q[2][A-1:S]}) begin
          mag_q[0] <= mag_q[0] >> 1;
          mag_q[1] <= mag_q[1] >> 1;
          mag_q[2] <= mag_q[2] >> 1;
        end
      end
      S_SQ: begin
        if (idx_q != 2'd0) begin
          v_q <= v_q + {{(SQ-2*S){1'b0}}, prod_q};
        end
        prod_q <= mag_sel[S-1:0] * mag_sel[S-1:0];
        res_q  <= '0;
        bit_q  <= {1'b1, {(SQ-1){1'b0}}};
      end
      S_SQRT: begin
        if (v_q >= trial) begin
          v_q   <= v_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_DIV: begin
        if (cnt_q == 6'd0) begin
          num_q <= {mag_sel[N-pnn_pkg::FracBits-1:0], {pnn_pkg::FracBits{1'b0}}}
                   + {{(N-L+1){1'b0}}, len[L-1:1]};
          rem_q <= '0;
        end else begin
          rem_q <= ge ? L'(rem2 - {1'b0, len}) : rem2[L-1:0];
          num_q <= {num_q[N-2:0], ge};
          if (cnt_q == 6'(N)) begin
            nrm_q[idx_q] <= neg_q[idx_q] ? O'(-{num_q[O-2:0], ge})
                                         : {num_q[O-2:0], ge};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= 2'd0;
      cnt_q       <= 6'd0;
      out_valid_q <= 1'b0;
      ox_q <= '0; oy_q <= '0; oz_q <= '0; od_q <= 1'b0;
    end else begin
      if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          idx_q <= 2'd0;
          if (!q_empty_i) begin
            state_q <= ~|{in_mag[0], in_mag[1], in_mag[2]} ? S_OUT : S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (!(|{mag_q[0][A-1:S], mag_q[1][A-1:S], mag_q[2][A-1:S]})) begin
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          idx_q <= idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (bit_q[0]) begin
            state_q <= S_DIV;
            idx_q   <= 2'd0;
            cnt_q   <= 6'd0;
          end
        end
        S_DIV: begin
          if (cnt_q == 6'(N)) begin
            cnt_q <= 6'd0;
            idx_q <= idx_q + 2'd1;
            if (idx_q == 2'd2) begin
              state_q <= S_OUT;
            end
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            ox_q <= nrm_q[0]; oy_q <= nrm_q[1]; oz_q <= nrm_q[2];
            od_q <= deg_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/polygon_normal_newell_top.sv =====
// Newell polygon normal. Vertices of one polygon enter in ring order through
// a push/full queue port, one vertex per request, signed Q8.8, with last_vertex_i
// on the final one. One result per polygon leaves through an empty/pop queue
// port: the unit normal in signed Q1.14 and a degenerate flag (zero-length sum,
// normal then zero).
// Throughput: a vertex is taken every cycle while full is low; after the last
// vertex, full stays high while the closing edge is added. The back end then
// scales, squares, takes the bit-serial square root, runs three bit-serial
// divisions and loads the output register; a zero sum goes straight to output.
// A two-entry queue between front and back lets the next polygons accumulate
// meanwhile; full stays high if that queue is full at a ring close.
// The result sits in an output register; while pop is low it holds and the
// back end waits with its next result, so the front keeps accepting until the
// queue fills. Reset clears all control; no result is pending after reset.
// depends on pnn_pkg, pnn_front, pnn_queue, pnn_back
`default_nettype none
module polygon_normal_newell_top (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  push,
  output logic                                 full,
  input  wire signed [pnn_pkg::CoordWidth-1:0] vertex_x_i,
  input  wire signed [pnn_pkg::CoordWidth-1:0] vertex_y_i,
  input  wire signed [pnn_pkg::CoordWidth-1:0] vertex_z_i,
  input  wire                                  last_vertex_i,
  output logic                                 empty,
  input  wire                                  pop,
  output logic signed [pnn_pkg::OutWidth-1:0]  normal_x_o,
  output logic signed [pnn_pkg::OutWidth-1:0]  normal_y_o,
  output logic signed [pnn_pkg::OutWidth-1:0]  normal_z_o,
  output logic                                 degenerate_o
);
  logic q_push, q_full, q_pop, q_empty;
  pnn_pkg::sums_t q_wdata, q_rdata;

  pnn_front u_front (
    .clk_i, .rst_ni,
    .push_i (push), .full_o (full),
    .vertex_x_i, .vertex_y_i, .vertex_z_i, .last_vertex_i,
    .q_push_o (q_push), .q_full_i (q_full), .q_data_o (q_wdata)
  );

  pnn_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (q_push), .data_i (q_wdata), .full_o (q_full),
    .pop_i (q_pop), .empty_o (q_empty), .data_o (q_rdata)
  );

  pnn_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i (q_empty), .q_data_i (q_rdata), .q_pop_o (q_pop),
    .pop_i (pop), .empty_o (empty),
    .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
  );
endmodule
`default_nettype wire

// ===== design/pnn_checker.sv =====
// port-level checks for the newell normal block, bound to the top level
// depends on polygon_normal_newell_top
`default_nettype none
module pnn_checker (
  input wire              clk_i,
  input wire              rst_ni,
  input wire              push,
  input wire              full,
  input wire              last_vertex_i,
  input wire              empty,
  input wire              pop,
  input wire signed [15:0] normal_x_o,
  input wire signed [15:0] normal_y_o,
  input wire signed [15:0] normal_z_o,
  input wire              degenerate_o
);
  // after the last vertex is taken, full goes high while the ring closes
  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full && last_vertex_i |=> full) else $error("no close cycle");
  a_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && degenerate_o |-> normal_x_o == 0 && normal_y_o == 0 && normal_z_o == 0)
    else $error("degenerate normal not zero");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> normal_x_o <= 16384 && normal_x_o >= -16384 &&
               normal_y_o <= 16384 && normal_y_o >= -16384 &&
               normal_z_o <= 16384 && normal_z_o >= -16384)
    else $error("normal out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(normal_x_o) && $stable(degenerate_o))
    else $error("result dropped");
endmodule

bind polygon_normal_newell_top pnn_checker u_pnn_checker (
  .clk_i, .rst_ni, .push, .full, .last_vertex_i, .empty, .pop,
  .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
);
`default_nettype wire
